// ----- hdl/bld_pkg.sv -----
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and codes for the bounded linked deque.
// ----------------------------------------------------------------------------
package bld_pkg;

  localparam int unsigned DefCapacity = 16;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_ERASE      = 3'd4,
    OP_INSERT     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_NOP        = 3'd7
  } bld_op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } bld_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC,
    ST_LINK,
    ST_POP_RD,
    ST_SCAN,
    ST_UNLINK,
    ST_INS_LINK,
    ST_INS_LINK2,
    ST_RD_HEAD,
    ST_RD_TAIL,
    ST_RD_BACK,
    ST_DONE
  } bld_state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } bld_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [4:0]         element_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } bld_rsp_t;

endpackage

// ----- hdl/bld_ram.sv -----
// ----------------------------------------------------------------------------
// bld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bld_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/bounded_linked_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_linked_deque
// Bounded doubly linked list of signed 32-bit words in a node store with a
// free list; push/pop at both ends, erase by key, insert after key, clear.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | bld_req_t request
//   out     | output    | out_valid_o / out_stall_i | bld_rsp_t result
//
// Each request passes DISPATCH, its op's states (SCAN steps over up to
// CAPACITY nodes; ALLOC is added when a freed slot is reused; a rejected
// push/insert or a miss skips ahead), the two end reads (dropped when the list
// ends empty) and DONE, one RAM read a cycle. Reset clears control state only;
// a fresh-slot counter hands out never-used slots once the free chain is empty.
// in_stall_o is high from accept until the result is loaded to the output reg.
//
module bounded_linked_deque
  import bld_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bld_req_t in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bld_rsp_t out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [CW-1:0] OneC = CW'(1);

  bld_state_e st_q, st_d;
  bld_op_e    op_q, op_d;
  logic signed [31:0] val_q, val_d, key_q, key_d;
  logic signed [31:0] pop_q, pop_d, front_q, front_d, back_q, back_d;
  bld_status_e stat_q, stat_d;
  logic [CW-1:0] count_q, count_d, fresh_q, fresh_d, idx_q, idx_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, fhead_q, fhead_d;
  logic [AW-1:0] s_q, s_d, nx_q, nx_d, pv_q, pv_d, n_q, n_d, p_q, p_d;
  logic     ovalid_q, ovalid_d;
  bld_rsp_t rsp_q, rsp_d;

  // RAM ports
  logic          val_we, nxt_we, prv_we, fre_we;
  logic [AW-1:0] val_wa, nxt_wa, prv_wa, fre_wa;
  logic [AW-1:0] val_ra, nxt_ra, prv_ra;
  logic [31:0]   val_wd, val_rd;
  logic [AW-1:0] nxt_wd, prv_wd, fre_wd, nxt_rd, prv_rd, fre_rd;

  bld_ram #(.Width(32), .Depth(CAPACITY)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(val_wd),
    .raddr_i(val_ra), .rdata_o(val_rd));
  bld_ram #(.Width(AW), .Depth(CAPACITY)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(nxt_ra), .rdata_o(nxt_rd));
  bld_ram #(.Width(AW), .Depth(CAPACITY)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(prv_ra), .rdata_o(prv_rd));
  // Free chain is always read at its head, so ALLOC sees the next free slot.
  bld_ram #(.Width(AW), .Depth(CAPACITY)) u_fre (
    .clk_i, .we_i(fre_we), .waddr_i(fre_wa), .wdata_i(fre_wd),
    .raddr_i(fhead_q), .rdata_o(fre_rd));

  logic is_push, is_pop, full, empty, stack_ne, hit, last, accept, unload;

  assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign is_pop   = (op_q == OP_POP_FRONT) || (op_q == OP_POP_BACK);
  assign full     = (count_q == CapC);
  assign empty    = (count_q == '0);
  assign stack_ne = (fresh_q != count_q);   // recycled slots are waiting
  assign hit      = (val_rd == key_q);      // the shared compare unit
  assign last     = ((idx_q + OneC) == count_q);
  assign accept   = in_valid_i && (st_q == ST_IDLE);
  assign unload   = !ovalid_q || !out_stall_i;

  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_o       = rsp_q;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) st_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (op_q)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) st_d = ST_RD_HEAD;
            else st_d = stack_ne ? ST_ALLOC : ST_LINK;
          end
          OP_POP_FRONT, OP_POP_BACK: st_d = empty ? ST_RD_HEAD : ST_POP_RD;
          OP_ERASE:  st_d = empty ? ST_RD_HEAD : ST_SCAN;
          OP_INSERT: st_d = (full || empty) ? ST_RD_HEAD : ST_SCAN;
          default:   st_d = ST_RD_HEAD;
        endcase
      end
      ST_ALLOC:  st_d = is_push ? ST_LINK : ST_INS_LINK;
      ST_LINK:   st_d = ST_RD_HEAD;
      ST_POP_RD: st_d = ST_UNLINK;
      ST_SCAN: begin
        priority if (hit) begin
          if (op_q == OP_ERASE) st_d = ST_UNLINK;
          else st_d = stack_ne ? ST_ALLOC : ST_INS_LINK;
        end else if (last) begin
          st_d = ST_RD_HEAD;
        end else begin
          st_d = ST_SCAN;
        end
      end
      ST_UNLINK:    st_d = ST_RD_HEAD;
      ST_INS_LINK:  st_d = ST_INS_LINK2;
      ST_INS_LINK2: st_d = ST_RD_HEAD;
      ST_RD_HEAD:   st_d = empty ? ST_DONE : ST_RD_TAIL;
      ST_RD_TAIL:   st_d = ST_RD_BACK;
      ST_RD_BACK:   st_d = ST_DONE;
      ST_DONE: begin
        if (unload) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    op_d = op_q;  val_d = val_q;  key_d = key_q;
    pop_d = pop_q;  front_d = front_q;  back_d = back_q;  stat_d = stat_q;
    count_d = count_q;  fresh_d = fresh_q;  idx_d = idx_q;
    head_d = head_q;  tail_d = tail_q;  fhead_d = fhead_q;
    s_d = s_q;  nx_d = nx_q;  pv_d = pv_q;  n_d = n_q;  p_d = p_q;
    rsp_d = rsp_q;
    ovalid_d = ovalid_q && out_stall_i;
    val_we = 1'b0;  nxt_we = 1'b0;  prv_we = 1'b0;  fre_we = 1'b0;
    val_wa = '0;  nxt_wa = '0;  prv_wa = '0;  fre_wa = '0;
    val_wd = '0;  nxt_wd = '0;  prv_wd = '0;  fre_wd = '0;
    val_ra = '0;  nxt_ra = '0;  prv_ra = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          op_d   = bld_op_e'(in_i.req_type);
          val_d  = in_i.value;
          key_d  = in_i.key;
          stat_d = STAT_OK;
          pop_d  = '0;
        end
      end
      ST_DISPATCH: begin
        unique case (op_q)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
              stat_d = STAT_FULL;
            end else if (!stack_ne) begin
              n_d     = fresh_q[AW-1:0];
              fresh_d = fresh_q + OneC;
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) stat_d = STAT_EMPTY;
            s_d    = (op_q == OP_POP_FRONT) ? head_q : tail_q;
            val_ra = s_d;
            nxt_ra = s_d;
            prv_ra = s_d;
          end
          OP_ERASE, OP_INSERT: begin
            priority if ((op_q == OP_INSERT) && full) stat_d = STAT_FULL;
            else if (empty) stat_d = STAT_NOT_FOUND;
            else stat_d = stat_q;
            p_d    = head_q;
            idx_d  = '0;
            val_ra = head_q;
            nxt_ra = head_q;
            prv_ra = head_q;
          end
          OP_CLEAR: begin
            count_d = '0;
            fresh_d = '0;
            head_d  = '0;
            tail_d  = '0;
          end
          default: ;
        endcase
      end
      ST_ALLOC: begin
        // Pop the recycled slot stack.
        n_d     = fhead_q;
        fhead_d = fre_rd;
      end
      ST_LINK: begin
        val_we = 1'b1;  val_wa = n_q;  val_wd = val_q;
        priority if (empty) begin
          head_d = n_q;
          tail_d = n_q;
        end else if (op_q == OP_PUSH_FRONT) begin
          nxt_we = 1'b1;  nxt_wa = n_q;     nxt_wd = head_q;
          prv_we = 1'b1;  prv_wa = head_q;  prv_wd = n_q;
          head_d = n_q;
        end else begin
          prv_we = 1'b1;  prv_wa = n_q;     prv_wd = tail_q;
          nxt_we = 1'b1;  nxt_wa = tail_q;  nxt_wd = n_q;
          tail_d = n_q;
        end
        count_d = count_q + OneC;
      end
      ST_POP_RD: begin
        pop_d = val_rd;
        nx_d  = nxt_rd;
        pv_d  = prv_rd;
      end
      ST_SCAN: begin
        priority if (hit) begin
          s_d  = p_q;
          nx_d = nxt_rd;
          pv_d = prv_rd;
          if ((op_q == OP_INSERT) && !stack_ne) begin
            n_d     = fresh_q[AW-1:0];
            fresh_d = fresh_q + OneC;
          end
        end else if (last) begin
          stat_d = STAT_NOT_FOUND;
        end else begin
          // Advance to the next node.
          p_d    = nxt_rd;
          idx_d  = idx_q + OneC;
          val_ra = nxt_rd;
          nxt_ra = nxt_rd;
          prv_ra = nxt_rd;
        end
      end
      ST_UNLINK: begin
        if (s_q == head_q) head_d = nx_q;
        else begin
          nxt_we = 1'b1;  nxt_wa = pv_q;  nxt_wd = nx_q;
        end
        if (s_q == tail_q) tail_d = pv_q;
        else begin
          prv_we = 1'b1;  prv_wa = nx_q;  prv_wd = pv_q;
        end
        // Push the slot on the recycled stack.
        fre_we  = 1'b1;  fre_wa = s_q;  fre_wd = fhead_q;
        fhead_d = s_q;
        count_d = count_q - OneC;
        if (count_q == OneC) begin
          head_d = '0;
          tail_d = '0;
        end
      end
      ST_INS_LINK: begin
        val_we = 1'b1;  val_wa = n_q;  val_wd = val_q;
        prv_we = 1'b1;  prv_wa = n_q;  prv_wd = s_q;
        nxt_we = 1'b1;  nxt_wa = n_q;  nxt_wd = nx_q;
      end
      ST_INS_LINK2: begin
        nxt_we = 1'b1;  nxt_wa = s_q;  nxt_wd = n_q;
        if (s_q == tail_q) tail_d = n_q;
        else begin
          prv_we = 1'b1;  prv_wa = nx_q;  prv_wd = n_q;
        end
        count_d = count_q + OneC;
      end
      ST_RD_HEAD: begin
        val_ra = head_q;
        if (empty) begin
          front_d = '0;
          back_d  = '0;
        end
      end
      ST_RD_TAIL: begin
        front_d = val_rd;
        val_ra  = tail_q;
      end
      ST_RD_BACK: begin
        back_d = val_rd;
      end
      ST_DONE: begin
        if (unload) begin
          rsp_d.status        = stat_q;
          rsp_d.popped_value  = pop_q;
          rsp_d.element_count = 5'(count_q);
          rsp_d.front_value   = front_q;
          rsp_d.back_value    = back_q;
          ovalid_d            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      count_q  <= '0;
      fresh_q  <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fhead_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      count_q  <= count_d;
      fresh_q  <= fresh_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fhead_q  <= fhead_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    val_q   <= val_d;
    key_q   <= key_d;
    pop_q   <= pop_d;
    front_q <= front_d;
    back_q  <= back_d;
    stat_q  <= stat_d;
    idx_q   <= idx_d;
    s_q     <= s_d;
    nx_q    <= nx_d;
    pv_q    <= pv_d;
    n_q     <= n_d;
    p_q     <= p_d;
    rsp_q   <= rsp_d;
  end

endmodule

// ----- verif/bounded_linked_deque_test.sv -----
// ----------------------------------------------------------------------------
// bounded_linked_deque_test
// Drives request words into the deque with random gaps and stalls, predicts
// every result word with a software list and compares field by field.
// ----------------------------------------------------------------------------
module bounded_linked_deque_test
  import bld_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned CycleLimit = 2000000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  bld_req_t in_i;
  logic     out_valid_o;
  logic     out_stall_i;
  bld_rsp_t out_o;

  bounded_linked_deque #(.CAPACITY(Cap)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  // Clock: 12 ns period.
  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Pending request words, filled up front by the stimulus block.
  bld_req_t pending_reqs[$];
  // Predicted result words, oldest first.
  bld_rsp_t expected_rsps[$];
  // Predictor's copy of the list contents, front at index 0.
  logic signed [31:0] deque_model[$];

  int  errors = 0;
  bit  stim_done = 1'b0;
  int  cycles = 0;
  int  hold_off = 0;      // long receiver stall, counted down in its own process
  bit  hold_started = 1'b0;

  // Compute the result of one request and advance the list copy.
  function automatic bld_rsp_t deque_apply(bld_req_t r);
    bld_rsp_t rsp;
    int       hit;
    hit = -1;
    rsp = '0;
    rsp.status = STAT_OK;
    for (int i = 0; i < deque_model.size(); i++) begin
      if (hit < 0 && deque_model[i] == r.key) hit = i;
    end
    case (bld_op_e'(r.req_type))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (deque_model.size() >= Cap) rsp.status = STAT_FULL;
        else if (r.req_type == OP_PUSH_FRONT) deque_model.insert(0, r.value);
        else deque_model.insert(deque_model.size(), r.value);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (deque_model.size() == 0) rsp.status = STAT_EMPTY;
        else if (r.req_type == OP_POP_FRONT) begin
          rsp.popped_value = deque_model[0];
          deque_model.delete(0);
        end else begin
          rsp.popped_value = deque_model[$];
          deque_model.delete(deque_model.size() - 1);
        end
      end
      OP_ERASE: begin
        if (hit < 0) rsp.status = STAT_NOT_FOUND;
        else deque_model.delete(hit);
      end
      OP_INSERT: begin
        if (deque_model.size() >= Cap) rsp.status = STAT_FULL;
        else if (hit < 0) rsp.status = STAT_NOT_FOUND;
        else deque_model.insert(hit + 1, r.value);
      end
      OP_CLEAR: deque_model.delete();
      default: ;
    endcase
    rsp.element_count = 5'(deque_model.size());
    if (deque_model.size() != 0) begin
      rsp.front_value = deque_model[0];
      rsp.back_value  = deque_model[$];
    end
    return rsp;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Pick a value that is likely to hit the small pool of keys in use.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $urandom_range(0, 7) - 3;
    endcase
  endfunction

  function automatic bld_req_t make_req(bld_op_e op, logic signed [31:0] v,
                                        logic signed [31:0] k);
    bld_req_t r;
    r.req_type = op;
    r.value    = v;
    r.key      = k;
    return r;
  endfunction

  // Append one request word to the pending queue.
  function automatic void add_req(bld_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Stimulus: directed corner cases, then random traffic shaped by phase.
  initial begin
    bld_req_t r;
    int       mode;
    // Empty-list corners.
    add_req(make_req(OP_POP_FRONT, 0, 0));
    add_req(make_req(OP_POP_BACK, 0, 0));
    add_req(make_req(OP_ERASE, 0, 5));
    add_req(make_req(OP_INSERT, 1, 5));
    add_req(make_req(OP_NOP, 32'sh1234, 32'sh55));
    add_req(make_req(OP_PUSH_BACK, 32'sh7fffffff, 0));
    add_req(make_req(OP_PUSH_FRONT, 32'sh80000000, 0));
    add_req(make_req(OP_PUSH_BACK, 32'sh80000000, 0));
    // Insert after the first of two equal elements, then after a middle element.
    add_req(make_req(OP_INSERT, -1, 32'sh80000000));
    add_req(make_req(OP_INSERT, 32'shffffffff, 32'sh7fffffff));
    add_req(make_req(OP_ERASE, 0, -1));
    add_req(make_req(OP_ERASE, 0, 32'sh7fffffff));
    add_req(make_req(OP_ERASE, 0, 32'sh22));
    // Fill to capacity, then full corners.
    for (int i = 0; i < 14; i++)
      add_req(make_req(OP_PUSH_BACK, i, 0));
    add_req(make_req(OP_PUSH_FRONT, 99, 0));
    add_req(make_req(OP_INSERT, 99, 3));
    add_req(make_req(OP_POP_BACK, 0, 0));
    add_req(make_req(OP_CLEAR, 0, 0));
    // Random part: phases lean toward filling, draining or searching.
    for (int n = 0; n < 1750; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      r.value = pick_value();
      r.key   = pick_value();
      case ($urandom_range(0, 9))
        0, 1: r.req_type = (mode == 0) ? OP_PUSH_BACK : OP_POP_FRONT;
        2, 3: r.req_type = (mode == 0) ? OP_PUSH_FRONT : OP_POP_BACK;
        4:    r.req_type = OP_PUSH_BACK;
        5:    r.req_type = OP_POP_FRONT;
        6, 7: r.req_type = (mode == 2) ? OP_ERASE : OP_INSERT;
        8:    r.req_type = ($urandom_range(0, 30) == 0) ? OP_CLEAR : OP_ERASE;
        default: r.req_type = 3'($urandom_range(0, 7));
      endcase
      add_req(r);
    end
    stim_done = 1'b1;
  end

  // Driver: offer words from the pending queue with random gaps; hold a
  // stalled word steady until it is taken.
  int gap_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
      gap_cnt    <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.insert(expected_rsps.size(), deque_apply(in_i));
        pending_reqs.delete(0);
      end
      if (in_valid_i && in_stall_o) begin
        // hold
      end else if (gap_cnt > 0) begin
        gap_cnt    <= gap_cnt - 1;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid_i <= 1'b1;
        in_i       <= pending_reqs[0];
        gap_cnt    <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: random gaps, plus one long hold-off early on so the
  // block fills up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      hold_off     <= 0;
      hold_started <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_started && cycles > 2000) begin
      hold_started <= 1'b1;
      hold_off     <= 300;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= (gap_len() != 0);
    end
  end

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    bld_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, out_o);
        errors++;
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        if (out_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, out_o.status);
          errors++;
        end
        if (out_o.popped_value !== want.popped_value) begin
          $display("%0t: popped_value expected %0d actual %0d", $realtime,
                   want.popped_value, out_o.popped_value);
          errors++;
        end
        if (out_o.element_count !== want.element_count) begin
          $display("%0t: element_count expected %0d actual %0d", $realtime,
                   want.element_count, out_o.element_count);
          errors++;
        end
        if (out_o.front_value !== want.front_value) begin
          $display("%0t: front_value expected %0d actual %0d", $realtime,
                   want.front_value, out_o.front_value);
          errors++;
        end
        if (out_o.back_value !== want.back_value) begin
          $display("%0t: back_value expected %0d actual %0d", $realtime,
                   want.back_value, out_o.back_value);
          errors++;
        end
      end
    end
  end

  // Reset, then wait for the traffic to drain or the cycle limit to hit.
  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    #1 rst_ni = 1'b1;
    while (!(stim_done && pending_reqs.size() == 0 && !in_valid_i &&
             expected_rsps.size() == 0) && cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("bounded_linked_deque_test failed");
    end else begin
      // Let any stray result word show up.
      repeat (40) @(posedge clk_i);
      if (errors == 0 && expected_rsps.size() == 0) begin
        $display("bounded_linked_deque_test passed");
      end else begin
        $display("bounded_linked_deque_test failed");
      end
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/bld_pkg.sv
hdl/bld_ram.sv
hdl/bounded_linked_deque.sv
verif/bounded_linked_deque_test.sv
